@@ rtl/pcp_pkg.sv @@
// Shared types and constants for the pinhole camera projection block.
package pcp_pkg;

  localparam int unsigned COORD_W  = 32;  // width of one Q-format value
  localparam int unsigned SUM_W    = 67;  // signed width of an exact row product
  localparam int unsigned MAG_W    = 66;  // unsigned magnitude of a row product
  localparam int unsigned QBITS    = 33;  // quotient bits kept before saturation
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_FIRST  = 3'd0,
    REG_ROW0_SECOND = 3'd1,
    REG_ROW1_FIRST  = 3'd2,
    REG_ROW1_SECOND = 3'd3,
    REG_ROW2_FIRST  = 3'd4,
    REG_ROW2_SECOND = 3'd5
  } cfg_reg_e;

  typedef logic [3:0][COORD_W-1:0] cam_row_t;
  typedef cam_row_t [2:0] cam_t;
  typedef logic [2:0][SUM_W-1:0] rows_t;

endpackage

@@ rtl/pcp_mac.sv @@
// Three-stage multiply-accumulate pipeline forming the three exact row products.
module pcp_mac #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  pcp_pkg::cam_t                 cam_i,
  input  logic [pcp_pkg::COORD_W-1:0]   x_i,
  input  logic [pcp_pkg::COORD_W-1:0]   y_i,
  input  logic [pcp_pkg::COORD_W-1:0]   z_i,
  output pcp_pkg::rows_t                p_o
);

  localparam int unsigned PW = 2 * pcp_pkg::COORD_W;
  localparam int unsigned OW = pcp_pkg::COORD_W + FRAC_BITS;

  logic signed [PW-1:0]   prod_q [3][3];
  logic signed [OW-1:0]   off_q  [3];
  logic signed [PW:0]     a_q    [3];
  logic signed [PW:0]     b_q    [3];
  logic [pcp_pkg::SUM_W-1:0] p_q [3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_q[r][0] <= $signed(cam_i[r][0]) * $signed(x_i);
        prod_q[r][1] <= $signed(cam_i[r][1]) * $signed(y_i);
        prod_q[r][2] <= $signed(cam_i[r][2]) * $signed(z_i);
        off_q[r]     <= {$signed(cam_i[r][3]), {FRAC_BITS{1'b0}}};
        a_q[r]       <= $signed({prod_q[r][0][PW-1], prod_q[r][0]})
                        + $signed({prod_q[r][1][PW-1], prod_q[r][1]});
        b_q[r]       <= $signed({prod_q[r][2][PW-1], prod_q[r][2]})
                        + $signed((PW+1)'(off_q[r]));
        p_q[r]       <= pcp_pkg::SUM_W'(a_q[r]) + pcp_pkg::SUM_W'(b_q[r]);
      end
    end
    assign p_o[r] = p_q[r];
  end

endmodule

@@ rtl/pcp_div.sv @@
// Pipelined restoring divider with overflow precheck, rounding and saturation.
module pcp_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [pcp_pkg::MAG_W-1:0]    num_i,
  input  logic [pcp_pkg::MAG_W-1:0]    den_i,
  input  logic                         neg_i,
  output logic [pcp_pkg::COORD_W-1:0]  quo_o,
  output logic                         sat_o
);

  localparam int unsigned NW = pcp_pkg::MAG_W + FRAC_BITS;
  localparam int unsigned QB = pcp_pkg::QBITS;
  localparam int unsigned CW = NW + QB;
  localparam logic [QB:0] QPOS_MAX = (QB+1)'(32'h7FFF_FFFF);
  localparam logic [QB:0] QNEG_MAX = (QB+1)'(32'h8000_0000);

  logic [NW-1:0]             rem_q [QB+1];
  logic [QB-1:0]             quo_q [QB+1];
  logic [pcp_pkg::MAG_W-1:0] den_q [QB+1];
  logic                      neg_q [QB+1];
  logic                      ovf_q [QB+1];
  logic [pcp_pkg::COORD_W-1:0] res_q;
  logic                      sat_q;

  // A quotient of 2^QB or more always saturates, so only QB bits are worked out.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {num_i, {FRAC_BITS{1'b0}}};
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
      ovf_q[0] <= CW'({num_i, {FRAC_BITS{1'b0}}}) >= {CW'(den_i) << QB};
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [CW-1:0] sub_w;
    logic          take_w;
    assign sub_w  = CW'(den_q[k]) << (QB - 1 - k);
    assign take_w = CW'(rem_q[k]) >= sub_w;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= take_w ? NW'(CW'(rem_q[k]) - sub_w) : rem_q[k];
        quo_q[k+1] <= {quo_q[k][QB-2:0], take_w};
        den_q[k+1] <= den_q[k];
        neg_q[k+1] <= neg_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  logic        rnd_w;
  logic [QB:0] qr_w;
  logic        sat_w;
  assign rnd_w = {rem_q[QB], 1'b0} >= (NW+1)'(den_q[QB]);
  assign qr_w  = {1'b0, quo_q[QB]} + (QB+1)'(rnd_w);
  assign sat_w = ovf_q[QB] || (neg_q[QB] ? (qr_w > QNEG_MAX) : (qr_w > QPOS_MAX));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q <= sat_w;
      if (sat_w) begin
        res_q <= neg_q[QB] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        res_q <= neg_q[QB] ? (32'd0 - qr_w[31:0]) : qr_w[31:0];
      end
    end
  end

  assign quo_o = res_q;
  assign sat_o = sat_q;

endmodule

@@ rtl/pinhole_camera_projection.sv @@
// Top level of the pinhole camera projection pipeline.
// Projects world points (X,Y,Z,1) through a 3x4 camera matrix held in six
// 64-bit registers, giving image coordinates u = p0/p2 and v = p1/p2.
// Input points arrive on the s_axis channel and results leave on m_axis.
// A request is accepted when tvalid and tready are high at a clock edge.
// The matrix is written through the cfg channel, which is always ready;
// writes with an index beyond the sixth register are dropped. Write the
// matrix only while no point is in flight.
// From input request to output valid a point passes three stages for the
// multiply and the two adder levels, one for magnitudes and the zero depth
// test, and 35 in each of the two dividers (a range precheck, one quotient
// bit per stage over 33 stages, and rounding with clamping).
// Throughput is one point per cycle while the receiver takes results.
// The whole pipeline advances together; when the output holds a result
// the receiver has not taken, every stage freezes and s_axis_tready
// drops, so nothing is lost or repeated.
// Reset clears the matrix to zero and empties the pipeline.
// A zero depth term gives u = v = 0 with the zero_depth flag set.
module pinhole_camera_projection #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // world_x[31:0], world_y[63:32], world_z[95:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // image_u[31:0], image_v[63:32]
  output logic [1:0]   m_axis_tuser,   // zero_depth[0], saturated[1]
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [pcp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pcp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned MAC_LAT = 3;
  localparam int unsigned DIV_LAT = pcp_pkg::QBITS + 2;
  localparam int unsigned LAT     = MAC_LAT + 1 + DIV_LAT;

  pcp_pkg::cam_t  cam_q;
  pcp_pkg::rows_t rows_w;
  logic           en_w;
  logic [LAT-1:0] vld_q;
  logic [LAT-1:0] zero_q;

  // The pipeline moves whenever the output stage is empty or being drained.
  assign en_w          = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en_w;
  assign cfg_ready_o   = 1'b1;

  // Camera matrix registers; each holds two entries, the first in the high half.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q <= '0;
    end else if (cfg_valid_i) begin
      case (pcp_pkg::cfg_reg_e'(cfg_index_i))
        pcp_pkg::REG_ROW0_FIRST:  cam_q[0][1:0] <= {cfg_data_i[31:0], cfg_data_i[63:32]};
        pcp_pkg::REG_ROW0_SECOND: cam_q[0][3:2] <= {cfg_data_i[31:0], cfg_data_i[63:32]};
        pcp_pkg::REG_ROW1_FIRST:  cam_q[1][1:0] <= {cfg_data_i[31:0], cfg_data_i[63:32]};
        pcp_pkg::REG_ROW1_SECOND: cam_q[1][3:2] <= {cfg_data_i[31:0], cfg_data_i[63:32]};
        pcp_pkg::REG_ROW2_FIRST:  cam_q[2][1:0] <= {cfg_data_i[31:0], cfg_data_i[63:32]};
        pcp_pkg::REG_ROW2_SECOND: cam_q[2][3:2] <= {cfg_data_i[31:0], cfg_data_i[63:32]};
        default: ;
      endcase
    end
  end

  // The packed row keeps entry c in slot c, so the high half goes to the lower column.
  // The concatenations above place data[63:32] in column 0 and data[31:0] in column 1
  // for the first pair; for the second pair column 2 gets the high half.

  pcp_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk_i (clk_i),
    .en_i  (en_w),
    .cam_i (cam_q),
    .x_i   (s_axis_tdata[31:0]),
    .y_i   (s_axis_tdata[63:32]),
    .z_i   (s_axis_tdata[95:64]),
    .p_o   (rows_w)
  );

  // Magnitudes, quotient signs and the zero depth test.
  logic [pcp_pkg::MAG_W-1:0] mag_q [3];
  logic                      neg_u_q, neg_v_q;

  for (genvar r = 0; r < 3; r++) begin : g_mag
    logic [pcp_pkg::SUM_W-1:0] abs_w;
    assign abs_w = rows_w[r][pcp_pkg::SUM_W-1] ? (pcp_pkg::SUM_W'(0) - rows_w[r]) : rows_w[r];
    always_ff @(posedge clk_i) begin
      if (en_w) begin
        mag_q[r] <= abs_w[pcp_pkg::MAG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      neg_u_q <= rows_w[0][pcp_pkg::SUM_W-1] ^ rows_w[2][pcp_pkg::SUM_W-1];
      neg_v_q <= rows_w[1][pcp_pkg::SUM_W-1] ^ rows_w[2][pcp_pkg::SUM_W-1];
    end
  end

  // Valid and zero depth marks travel alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      zero_q <= '0;
    end else if (en_w) begin
      vld_q  <= {vld_q[LAT-2:0], s_axis_tvalid};
      zero_q <= {zero_q[LAT-2:MAC_LAT], (rows_w[2] == '0), zero_q[MAC_LAT-2:0], 1'b0};
    end
  end

  logic [31:0] u_w, v_w;
  logic        sat_u_w, sat_v_w;

  pcp_div #(.FRAC_BITS(FRAC_BITS)) u_div_u (
    .clk_i (clk_i), .en_i (en_w), .num_i (mag_q[0]), .den_i (mag_q[2]),
    .neg_i (neg_u_q), .quo_o (u_w), .sat_o (sat_u_w)
  );

  pcp_div #(.FRAC_BITS(FRAC_BITS)) u_div_v (
    .clk_i (clk_i), .en_i (en_w), .num_i (mag_q[1]), .den_i (mag_q[2]),
    .neg_i (neg_v_q), .quo_o (v_w), .sat_o (sat_v_w)
  );

  logic zero_w;
  assign zero_w        = zero_q[LAT-1];
  assign m_axis_tvalid = vld_q[LAT-1];
  assign m_axis_tdata  = zero_w ? 64'd0 : {v_w, u_w};
  assign m_axis_tuser  = {!zero_w && (sat_u_w || sat_v_w), zero_w};

`ifndef ASSERT_OFF
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1]) else $error("flags both set");
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 64'd0) else $error("zero depth data");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("accept during stall");
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0]) else $error("accepted point lost");
`endif

endmodule

@@ tb/pinhole_camera_projection_test.sv @@
// Self-checking testbench for the pinhole camera projection block.
`timescale 1ns / 100ps

module pinhole_camera_projection_test;

  localparam int unsigned FRAC = 16;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [31:0] wz;
    logic [31:0] wy;
    logic [31:0] wx;
  } point_t;

  typedef struct packed {
    logic [31:0] u;
    logic [31:0] v;
    logic        zero_depth;
    logic        saturated;
  } image_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [pcp_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [pcp_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  pinhole_camera_projection #(.FRAC_BITS(FRAC)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Camera matrix as the predictor sees it, one signed entry per element.
  logic signed [31:0] camera [3][4];

  point_t pending_points[$];
  image_t expected_images[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit timed_out = 1'b0;

  // Handshake seen at the rising edge, for use by the sender on the falling edge.
  logic s_axis_tready_q = 1'b0;

  // Rounded and clamped quotient of two exact row products.
  function automatic logic [31:0] divide_round(input logic signed [66:0] num,
                                               input logic signed [66:0] den,
                                               inout logic sat);
    logic [127:0] n, d, q, r;
    logic neg;
    neg = num[66] ^ den[66];
    n = num[66] ? 128'(-num) : 128'(num);
    d = den[66] ? 128'(-den) : 128'(den);
    n = n << FRAC;
    q = n / d;
    r = n % d;
    if ((r << 1) >= d) q = q + 1;
    if (!neg) begin
      if (q > 128'h7FFF_FFFF) begin
        sat = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return q[31:0];
    end
    if (q > 128'h8000_0000) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return 32'(-q[31:0]);
  endfunction

  function automatic image_t project_point(input point_t p);
    logic signed [66:0] prod [3];
    image_t res;
    logic sat;
    sat = 1'b0;
    for (int r = 0; r < 3; r++) begin
      prod[r] = 67'(longint'(camera[r][0]) * longint'($signed(p.wx)))
              + 67'(longint'(camera[r][1]) * longint'($signed(p.wy)))
              + 67'(longint'(camera[r][2]) * longint'($signed(p.wz)))
              + 67'(longint'(camera[r][3]) <<< FRAC);
    end
    res = '0;
    if (prod[2] == 0) begin
      res.zero_depth = 1'b1;
      return res;
    end
    res.u = divide_round(prod[0], prod[2], sat);
    res.v = divide_round(prod[1], prod[2], sat);
    res.saturated = sat;
    return res;
  endfunction

  // Writes one matrix register while the pipeline is empty.
  task automatic write_register(input pcp_pkg::cfg_reg_e idx, input logic [63:0] value);
    int r, c;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    r = int'(idx) >> 1;
    c = (int'(idx) & 1) * 2;
    camera[r][c] = value[63:32];
    camera[r][c + 1] = value[31:0];
  endtask

  task automatic load_camera(input logic [63:0] regs [6]);
    write_register(pcp_pkg::REG_ROW0_FIRST, regs[0]);
    write_register(pcp_pkg::REG_ROW0_SECOND, regs[1]);
    write_register(pcp_pkg::REG_ROW1_FIRST, regs[2]);
    write_register(pcp_pkg::REG_ROW1_SECOND, regs[3]);
    write_register(pcp_pkg::REG_ROW2_FIRST, regs[4]);
    write_register(pcp_pkg::REG_ROW2_SECOND, regs[5]);
  endtask

  // Waits until the queue is empty and every result has come back.
  task automatic wait_drained();
    while (pending_points.size() != 0 || expected_images.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] q16(input int whole);
    return 32'(whole) << FRAC;
  endfunction

  // Random coordinate: mostly modest values, sometimes any 32-bit pattern.
  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 9) < 2) return $urandom();
    return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
  endfunction

  task automatic queue_point(input logic [31:0] x, y, z);
    point_t p;
    p.wx = x;
    p.wy = y;
    p.wz = z;
    pending_points = {pending_points, p};
  endtask

  // Sender: presents the head of the queue, holds it until the request is taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready_q) begin
        // request was taken at the last rising edge
      end
      if (!s_axis_tvalid || s_axis_tready_q) begin
        if (pending_points.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_points[0];
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on accepted inputs and checks accepted outputs.
  always @(posedge clk_i) begin
    image_t got, want;
    if (!rst_ni) begin
      s_axis_tready_q <= 1'b0;
    end else begin
      s_axis_tready_q <= s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_images = {expected_images, project_point(point_t'(s_axis_tdata))};
        void'(pending_points.pop_front());
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.u = m_axis_tdata[31:0];
        got.v = m_axis_tdata[63:32];
        got.zero_depth = m_axis_tuser[0];
        got.saturated = m_axis_tuser[1];
        if (expected_images.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result: u=%h v=%h zd=%b sat=%b",
                     got.u, got.v, got.zero_depth, got.saturated);
        end else begin
          want = expected_images.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected u=%h v=%h zd=%b sat=%b, got u=%h v=%h zd=%b sat=%b",
                       want.u, want.v, want.zero_depth, want.saturated,
                       got.u, got.v, got.zero_depth, got.saturated);
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (pending_points.size() == 0 && expected_images.size() == 0))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] regs [6];
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++)
        camera[r][c] = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset matrix is all zero, so every point must report zero depth.
    queue_point(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
    wait_drained();

    // Simple camera: u = X/Z, v = Y/Z. Covers field extremes, zero Z, ties.
    regs = '{{q16(1), 32'h0}, 64'h0, {32'h0, q16(1)}, 64'h0, 64'h0, {q16(1), 32'h0}};
    load_camera(regs);
    queue_point(q16(3), q16(-5), q16(2));
    queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    queue_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_point(q16(1), q16(1), 32'h0);
    queue_point(32'h0000_0001, 32'hFFFF_FFFF, q16(2));
    queue_point(32'h0000_0003, 32'hFFFF_FFFD, q16(2));
    queue_point(32'h0, 32'h0, 32'h8000_0000);
    queue_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_point(q16(-32768), q16(16384), 32'h0000_8000);
    queue_point(32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFF);
    wait_drained();

    // Extreme matrix entries in every slot.
    regs = '{{32'h7FFF_FFFF, 32'h8000_0000}, {32'hFFFF_FFFF, 32'h7FFF_FFFF},
             {32'h8000_0000, 32'h0000_0001}, {32'h7FFF_FFFF, 32'h8000_0000},
             {32'h0000_0001, 32'hFFFF_FFFF}, {32'h8000_0000, 32'h7FFF_FFFF}};
    load_camera(regs);
    queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_point(32'h0, 32'h0, 32'h0);
    queue_point(32'h1, 32'h0, 32'h0);
    queue_point(32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h0F0F_F0F0);
    wait_drained();

    // Random phases with realistic and wild matrices and all idling patterns.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (int k = 0; k < 6; k++)
        regs[k] = (phase >= 6) ? {$urandom(), $urandom()}
                               : {rand_coord(), rand_coord()};
      load_camera(regs);
      for (int n = 0; n < 175; n++) begin
        if ($urandom_range(0, 19) == 0)
          queue_point($urandom(), $urandom(), $urandom());
        else
          queue_point(rand_coord(), rand_coord(), rand_coord());
      end
      wait_drained();
    end

    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
